FILE: hdl/bsm_pkg.sv
// ----------------------------------------------------------------------------
// Bank switch mapper package
// Shared types, codes and constants for the bank switching mapper with its
// scanline IRQ counter.
// ----------------------------------------------------------------------------
package bsm_pkg;

  // Remainder unit: one quotient bit per cycle over an 8-bit bank number.
  localparam int unsigned DivSteps = 8;
  localparam int unsigned CntW     = $clog2(DivSteps);

  localparam int unsigned BankW    = 8;
  localparam int unsigned CountW   = 9;
  localparam int unsigned MemAddrW = 21;

  // Largest bank count honored; anything above is treated as this.
  localparam logic [CountW-1:0] MaxBanks = 9'd256;

  // Item kinds.
  typedef enum logic [1:0] {
    MODE_CPU_WRITE  = 2'd0,
    MODE_PRG_READ   = 2'd1,
    MODE_CHR_ACCESS = 2'd2,
    MODE_A12_RISE   = 2'd3
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_PRG_TOTAL  = 2'd0,
    CFG_CHR_TOTAL  = 2'd1,
    CFG_CHR_WRITE  = 2'd2,
    CFG_HDR_MIRROR = 2'd3
  } cfg_idx_e;

  // CPU register decode: {address[14:13], address[0]} above 0x8000.
  typedef enum logic [2:0] {
    REG_BANK_SELECT = 3'b000,
    REG_BANK_DATA   = 3'b001,
    REG_MIRRORING   = 3'b010,
    REG_UNUSED      = 3'b011,
    REG_IRQ_LATCH   = 3'b100,
    REG_IRQ_RELOAD  = 3'b101,
    REG_IRQ_DISABLE = 3'b110,
    REG_IRQ_ENABLE  = 3'b111
  } reg_op_e;

  // PRG window decode: address[14:13].
  typedef enum logic [1:0] {
    PRG_WIN_8000 = 2'd0,
    PRG_WIN_A000 = 2'd1,
    PRG_WIN_C000 = 2'd2,
    PRG_WIN_E000 = 2'd3
  } prg_win_e;

  localparam logic [1:0] MirrorFour = 2'd2;

  localparam logic [BankW-1:0] BankResetVal [8] = '{
    8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        ppu_write;
  } in_item_t;

  typedef struct packed {
    logic [MemAddrW-1:0] mem_address;
    logic                address_valid;
    logic                chr_write_enable;
    logic                irq_line;
    logic [1:0]          mirroring;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic div_step;
    logic out_load;
  } bsm_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } bsm_status_t;

endpackage

FILE: hdl/bsm_if.sv
// ----------------------------------------------------------------------------
// Bank switch mapper channel interfaces
// Valid/ready channels for request transactions and result transactions.
// ----------------------------------------------------------------------------
interface bsm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic        ppu_write;

  modport source (output valid, output mode, output address, output write_data,
                  output ppu_write, input ready);
  modport sink   (input valid, input mode, input address, input write_data,
                  input ppu_write, output ready);
endinterface

interface bsm_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] mem_address;
  logic        address_valid;
  logic        chr_write_enable;
  logic        irq_line;
  logic [1:0]  mirroring;

  modport source (output valid, output mem_address, output address_valid,
                  output chr_write_enable, output irq_line, output mirroring,
                  input ready);
  modport sink   (input valid, input mem_address, input address_valid,
                  input chr_write_enable, input irq_line, input mirroring,
                  output ready);
endinterface

FILE: hdl/bsm_ctrl.sv
// ----------------------------------------------------------------------------
// Bank switch mapper controller
// Sequences one transaction through execute, remainder steps and result load.
// ----------------------------------------------------------------------------
module bsm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bsm_pkg::bsm_status_t status_i,
  output bsm_pkg::bsm_cmd_t    cmd_o
);
  import bsm_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic cnt_last;

  assign cnt_last = (cnt_q == CntW'(DivSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cnt_d   = '0;
        state_d = status_i.need_div ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_EXEC:   cmd_o.exec     = 1'b1;
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_FINISH: cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EXEC))
    else $error("accepted transaction did not enter execute");
  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_last) |=> (state_q == ST_FINISH))
    else $error("remainder sequence did not end after its last step");
  a_load_only_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (state_q == ST_FINISH && status_i.out_free))
    else $error("result loaded outside finish or into a full register");
`endif
endmodule

FILE: hdl/bsm_datapath.sv
// ----------------------------------------------------------------------------
// Bank switch mapper datapath
// Mapper registers, IRQ counter, address translation, bit-serial bank
// remainder unit and the result register.
// ----------------------------------------------------------------------------
module bsm_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [8:0]            cfg_data_i,
  input  bsm_pkg::in_item_t     in_item_i,
  input  bsm_pkg::bsm_cmd_t     cmd_i,
  output bsm_pkg::bsm_status_t  status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output bsm_pkg::out_item_t    out_item_o
);
  import bsm_pkg::*;

  // Configuration.
  logic [CountW-1:0] prg_total_q, chr_total_q;
  logic              chr_writable_q;

  // Mapper state.
  logic [2:0]       bank_sel_q;
  logic [BankW-1:0] bank_q [8];
  logic             prg_swap_q, chr_invert_q;
  logic [7:0]       irq_latch_q, irq_count_q;
  logic             irq_reload_q, irq_enable_q, irq_pending_q;
  logic [1:0]       mirror_q;

  // Item and remainder unit.
  in_item_t          item_q;
  logic              valid_q, is_chr_q, we_q;
  logic [BankW-1:0]  dividend_q;
  logic [CountW-1:0] divisor_q, rem_q;
  logic [12:0]       off_q;

  logic              out_valid_q;
  out_item_t         out_item_q;

  // ---------------------------------------------------------------- decode
  logic [CountW-1:0] n_prg, n_chr;
  logic [BankW-1:0]  prg_second, prg_last, prg_bank, chr_bank;
  logic [12:0]       chr_a, chr_ai;
  logic              exec_valid, exec_chr, exec_we;
  logic [BankW-1:0]  exec_bank;
  logic [CountW-1:0] exec_n;
  reg_op_e           reg_op;
  logic [7:0]        irq_count_next;
  logic              irq_reload_now;

  assign n_prg = (prg_total_q > MaxBanks) ? MaxBanks : prg_total_q;
  assign n_chr = (chr_total_q > MaxBanks) ? MaxBanks : chr_total_q;

  assign prg_last   = BankW'(n_prg - CountW'(1));
  assign prg_second = (n_prg >= CountW'(2)) ? BankW'(n_prg - CountW'(2)) : '0;

  always_comb begin
    unique case (prg_win_e'(item_q.address[14:13]))
      PRG_WIN_8000: prg_bank = prg_swap_q ? prg_second : bank_q[6];
      PRG_WIN_A000: prg_bank = bank_q[7];
      PRG_WIN_C000: prg_bank = prg_swap_q ? bank_q[6] : prg_second;
      PRG_WIN_E000: prg_bank = prg_last;
      default:      prg_bank = prg_last;
    endcase
  end

  assign chr_a  = item_q.address[12:0];
  assign chr_ai = chr_a ^ {chr_invert_q, 12'd0};

  always_comb begin
    priority if (chr_ai[12:11] == 2'b00) begin
      chr_bank = {bank_q[0][7:1], chr_a[10]};
    end else if (chr_ai[12:11] == 2'b01) begin
      chr_bank = {bank_q[1][7:1], chr_a[10]};
    end else begin
      chr_bank = bank_q[3'd2 + {1'b0, chr_ai[11:10]}];
    end
  end

  always_comb begin
    exec_valid = 1'b0;
    exec_chr   = 1'b0;
    exec_we    = 1'b0;
    exec_bank  = prg_bank;
    exec_n     = n_prg;
    unique case (mode_e'(item_q.mode))
      MODE_PRG_READ: begin
        exec_valid = (n_prg != '0) && item_q.address[15];
      end
      MODE_CHR_ACCESS: begin
        exec_chr   = 1'b1;
        exec_bank  = chr_bank;
        exec_n     = n_chr;
        exec_valid = (n_chr != '0);
        exec_we    = item_q.ppu_write & chr_writable_q;
      end
      MODE_CPU_WRITE, MODE_A12_RISE: ;
      default: ;
    endcase
  end

  assign status_o.need_div = exec_valid;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign reg_op = reg_op_e'({item_q.address[14:13], item_q.address[0]});

  assign irq_reload_now = (irq_count_q == '0) || irq_reload_q;
  assign irq_count_next = irq_reload_now ? irq_latch_q : irq_count_q - 8'd1;

  // ---------------------------------------------------------- mapper state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_total_q    <= '0;
      chr_total_q    <= '0;
      chr_writable_q <= 1'b0;
      bank_sel_q     <= '0;
      bank_q         <= BankResetVal;
      prg_swap_q     <= 1'b0;
      chr_invert_q   <= 1'b0;
      irq_latch_q    <= '0;
      irq_count_q    <= '0;
      irq_reload_q   <= 1'b0;
      irq_enable_q   <= 1'b0;
      irq_pending_q  <= 1'b0;
      mirror_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_PRG_TOTAL:  prg_total_q    <= cfg_data_i;
          CFG_CHR_TOTAL:  chr_total_q    <= cfg_data_i;
          CFG_CHR_WRITE:  chr_writable_q <= cfg_data_i[0];
          CFG_HDR_MIRROR: begin
            // A header value of three is treated as four-screen.
            mirror_q <= (cfg_data_i[1:0] > MirrorFour) ? MirrorFour : cfg_data_i[1:0];
          end
          default: ;
        endcase
      end
      if (cmd_i.exec && mode_e'(item_q.mode) == MODE_CPU_WRITE && item_q.address[15]) begin
        unique case (reg_op)
          REG_BANK_SELECT: begin
            bank_sel_q   <= item_q.write_data[2:0];
            prg_swap_q   <= item_q.write_data[6];
            chr_invert_q <= item_q.write_data[7];
          end
          REG_BANK_DATA: begin
            // The two 2 KiB CHR banks always start on an even bank.
            bank_q[bank_sel_q] <= {item_q.write_data[7:1],
                                   item_q.write_data[0] & (bank_sel_q[2:1] != 2'b00)};
          end
          REG_MIRRORING: begin
            if (mirror_q != MirrorFour) mirror_q <= {1'b0, item_q.write_data[0]};
          end
          REG_IRQ_LATCH:  irq_latch_q <= item_q.write_data;
          REG_IRQ_RELOAD: begin
            irq_count_q  <= '0;
            irq_reload_q <= 1'b1;
          end
          REG_IRQ_DISABLE: begin
            irq_enable_q  <= 1'b0;
            irq_pending_q <= 1'b0;
          end
          REG_IRQ_ENABLE: irq_enable_q <= 1'b1;
          REG_UNUSED: ;
          default: ;
        endcase
      end
      if (cmd_i.exec && mode_e'(item_q.mode) == MODE_A12_RISE) begin
        irq_count_q  <= irq_count_next;
        irq_reload_q <= 1'b0;
        if (irq_count_next == '0 && irq_enable_q) irq_pending_q <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------ remainder unit
  logic [CountW-1:0] rem_shift, rem_next;

  assign rem_shift = {rem_q[BankW-1:0], dividend_q[BankW-1]};
  assign rem_next  = (rem_shift >= divisor_q) ? rem_shift - divisor_q : rem_shift;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_item_i;
    if (cmd_i.exec) begin
      valid_q    <= exec_valid;
      is_chr_q   <= exec_chr;
      we_q       <= exec_we;
      dividend_q <= exec_bank;
      divisor_q  <= exec_n;
      rem_q      <= '0;
      off_q      <= item_q.address[12:0];
    end else if (cmd_i.div_step) begin
      rem_q      <= rem_next;
      dividend_q <= {dividend_q[BankW-2:0], 1'b0};
    end
  end

  // ------------------------------------------------------ result register
  out_item_t result;

  always_comb begin
    result                  = '0;
    result.irq_line         = irq_pending_q;
    result.mirroring        = mirror_q;
    if (valid_q) begin
      result.address_valid    = 1'b1;
      result.chr_write_enable = we_q;
      result.mem_address      = is_chr_q ? {3'b000, rem_q[BankW-1:0], off_q[9:0]}
                                         : {rem_q[BankW-1:0], off_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_item_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef NO_ASSERTIONS
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && valid_q) |-> (rem_q < divisor_q))
    else $error("bank remainder not reduced below bank count");
  a_irq_rise_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(irq_pending_q) |-> $past(cmd_i.exec))
    else $error("IRQ raised without an executed transaction");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_item_q)))
    else $error("waiting result changed or dropped");
`endif
endmodule

FILE: hdl/bank_switch_mapper_irq_counter_top.sv
// ----------------------------------------------------------------------------
// Bank switch mapper with scanline IRQ counter
// Translates CPU and PPU accesses to banked physical addresses, takes mapper
// register writes and clocks the scanline IRQ counter.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake     Payload
//   in_i     sink       valid/ready   mode, address, write_data, ppu_write
//   out_o    source     valid/ready   mem_address, address_valid,
//                                     chr_write_enable, irq_line, mirroring
//   cfg      sink       cfg_we_i      cfg_index_i, cfg_data_i
//
// A translating transaction is latched on acceptance, decoded, reduced by a
// bit-serial remainder of the bank number by the bank count, and then loaded
// into the result register. Register writes, rising edges on A12 and open-bus reads
// skip the remainder. A full result register stalls only the final load;
// a new request is taken while the previous result waits. Reset is
// asynchronous and active low and leaves the mapper registers at their
// power-up values.
//
module bank_switch_mapper_irq_counter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i,
  bsm_in_if.sink     in_i,
  bsm_out_if.source  out_o
);
  import bsm_pkg::*;

  bsm_cmd_t    cmd;
  bsm_status_t status;
  in_item_t    in_item;
  out_item_t   out_item;
  logic        out_valid;

  // Pack the request fields into one item for the datapath.
  assign in_item.mode       = in_i.mode;
  assign in_item.address    = in_i.address;
  assign in_item.write_data = in_i.write_data;
  assign in_item.ppu_write  = in_i.ppu_write;

  // The controller owns the request handshake and steps the datapath.
  bsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds all mapper state and the result register.
  bsm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

  assign out_o.valid            = out_valid;
  assign out_o.mem_address      = out_item.mem_address;
  assign out_o.address_valid    = out_item.address_valid;
  assign out_o.chr_write_enable = out_item.chr_write_enable;
  assign out_o.irq_line         = out_item.irq_line;
  assign out_o.mirroring        = out_item.mirroring;

endmodule
